FILE: design/ralloc_pkg.sv
// shared types and constants for the range allocator
// no dependencies
package ralloc_pkg;

    localparam int INDEX_BITS = 20;
    localparam int CNT_W  = INDEX_BITS + 1;
    localparam int BASE_W = INDEX_BITS;
    localparam int EXT_W  = INDEX_BITS + 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_EXH  = 2'd1;
    localparam logic [1:0] ST_IGN  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DESC_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_START = 3'd5;

    typedef struct packed {
        logic              opcode;
        logic [CNT_W-1:0]  count;
        logic [BASE_W-1:0] base_index;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [BASE_W-1:0] alloc_base;
        logic [63:0]       cpu_handle;
        logic [63:0]       gpu_handle;
    } rsp_t;

    // one free range as stored in the table
    typedef struct packed {
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] len;
    } ent_t;

    // operands of the shared step unit
    typedef struct packed {
        logic [EXT_W-1:0] a;
        logic [EXT_W-1:0] b;
        logic [EXT_W-1:0] c;
        logic [EXT_W-1:0] d;
        logic [EXT_W-1:0] e;
        logic [EXT_W-1:0] f;
        logic [EXT_W-1:0] g;
        logic [EXT_W-1:0] h;
        logic [EXT_W-1:0] k;
    } step_in_t;

    typedef struct packed {
        logic [EXT_W-1:0] sum;
        logic             le;
        logic [EXT_W-1:0] dif;
        logic             ge;
        logic [EXT_W-1:0] len;
        logic             lt;
    } step_out_t;

endpackage

FILE: design/ralloc_table.sv
// free-range table memory, two banks, one write and one registered read port
// depends on ralloc_pkg
module ralloc_table
    import ralloc_pkg::*;
#(
    parameter int ADDR_W = 7
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  ent_t              wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output ent_t              rdata
);

    ent_t mem [2**ADDR_W];
    ent_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ralloc_step.sv
// shared add and compare unit used by the sequencer's check, bump and merge steps
// depends on ralloc_pkg
module ralloc_step
    import ralloc_pkg::*;
(
    input  step_in_t  op,
    output step_out_t res
);

    logic [EXT_W-1:0] sum;

    always_comb
    begin
        sum     = op.a + op.b;
        res.sum = sum;
        res.le  = (sum <= op.c);
        res.dif = op.d - op.e;
        res.ge  = (op.d >= op.e);
        res.len = op.f - op.g;
        res.lt  = (op.h < op.k);
    end

endmodule

FILE: design/range_allocator_first_fit_coalesce.sv
// Range allocator: contiguous slot runs handed out first fit from a sorted free-range
// table, falling back to a bump pointer; releases are inserted and coalesced. One request
// at a time: an allocate scans the table entry by entry (memory read, then a fit check
// in the shared step unit); when the fitting range is emptied, every later entry is
// moved down one place instead. A release is checked, then streams the table through
// the merge into the spare bank, slots the released run in if no larger base came up,
// and flushes the last range. Every request then passes the handle multiply and add;
// the table memory's single read port sets the pace of scan, squeeze and merge. The
// block is ready again once the result goes to the output register, where it sits, so
// the next request is taken while it waits. Depends on ralloc_pkg, ralloc_table and
// ralloc_step.
module range_allocator_first_fit_coalesce
    import ralloc_pkg::*;
#(
    parameter int MAX_FREE_RANGES = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_FREE_RANGES > 1) ? $clog2(MAX_FREE_RANGES) : 1;
    localparam int RC_W = $clog2(MAX_FREE_RANGES + 1);
    localparam int ADDR_W = IDX_W + 1;
    // slot limit set by the index width
    localparam logic [EXT_W-1:0] LIM = EXT_W'(1) << INDEX_BITS;

    // sequencer codes
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_A_REQ   = 4'd1;
    localparam logic [3:0] S_A_CHK   = 4'd2;
    localparam logic [3:0] S_A_SHREQ = 4'd3;
    localparam logic [3:0] S_A_SHWR  = 4'd4;
    localparam logic [3:0] S_A_BUMP  = 4'd5;
    localparam logic [3:0] S_R_CHK   = 4'd6;
    localparam logic [3:0] S_R_REQ   = 4'd7;
    localparam logic [3:0] S_R_MRG   = 4'd8;
    localparam logic [3:0] S_R_LAST  = 4'd9;
    localparam logic [3:0] S_R_FLUSH = 4'd10;
    localparam logic [3:0] S_MUL     = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    // configuration
    logic [CNT_W-1:0] capacity_reg;
    logic [11:0]      dsize_reg;
    logic             shader_reg;
    logic             heap_reg;
    logic [63:0]      cpu_start_reg;
    logic [63:0]      gpu_start_reg;

    // control state
    logic [3:0]       state_reg, state_next;
    logic [RC_W-1:0]  rc_reg, rc_next;
    logic [CNT_W-1:0] bump_reg, bump_next;
    logic             bank_reg, bank_next;
    logic [RC_W-1:0]  i_reg, i_next;
    logic [RC_W-1:0]  w_reg, w_next;
    logic             placed_reg, placed_next;
    logic             pend_reg, pend_next;
    logic             ovf_reg, ovf_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // payload state
    req_t             req_reg, req_next;
    logic [1:0]       status_reg, status_next;
    logic [CNT_W-1:0] grant_reg, grant_next;
    logic [EXT_W-1:0] pb_reg, pb_next;
    logic [EXT_W-1:0] pe_reg, pe_next;
    logic [63:0]      off_reg;
    rsp_t             rsp_reg, rsp_next;

    // table port
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    ent_t              mem_wdata, mem_rdata;

    step_in_t  su_in;
    step_out_t su_out;

    logic [EXT_W-1:0] eff_cap;
    logic [EXT_W-1:0] cnt_x, base_x, rb_x, rl_x, rd_base_x, rd_len_x;
    logic             take_new;
    logic [RC_W:0]    i_plus1, i_plus2;
    logic             more_after_i, more_after_i2;

    ralloc_table #(.ADDR_W(ADDR_W)) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ralloc_step u_step (
        .op  (su_in),
        .res (su_out)
    );

    always_comb
    begin
        eff_cap = ({1'b0, capacity_reg} < LIM) ? {1'b0, capacity_reg} : LIM;
        cnt_x = {1'b0, req_reg.count};
        base_x = {2'b00, req_reg.base_index};
        rd_base_x = {1'b0, mem_rdata.base};
        rd_len_x = {1'b0, mem_rdata.len};
        i_plus1 = {1'b0, i_reg} + (RC_W+1)'(1);
        i_plus2 = {1'b0, i_reg} + (RC_W+1)'(2);
        more_after_i = i_plus1 < {1'b0, rc_reg};
        more_after_i2 = i_plus2 < {1'b0, rc_reg};
    end

    // element fed to the merge: the released run goes ahead of the first larger base
    always_comb
    begin
        take_new = (!placed_reg && su_out.lt) || (state_reg == S_R_LAST);
        rb_x = take_new ? base_x : rd_base_x;
        rl_x = take_new ? cnt_x : rd_len_x;
    end

    // operand steering into the shared unit
    always_comb
    begin
        su_in = '0;
        case (state_reg)
            S_A_CHK:
            begin
                su_in.a = rd_base_x;
                su_in.b = cnt_x;
                su_in.d = rd_len_x;
                su_in.e = cnt_x;
            end
            S_A_BUMP:
            begin
                su_in.a = {1'b0, bump_reg};
                su_in.b = cnt_x;
                su_in.c = eff_cap;
            end
            S_R_CHK:
            begin
                su_in.a = base_x;
                su_in.b = cnt_x;
                su_in.c = eff_cap;
                su_in.d = base_x;
                su_in.e = eff_cap;
            end
            S_R_MRG, S_R_LAST, S_R_FLUSH:
            begin
                su_in.a = rb_x;
                su_in.b = rl_x;
                su_in.c = pe_reg;
                su_in.d = pe_reg;
                su_in.e = rb_x;
                su_in.f = pe_reg;
                su_in.g = pb_reg;
                su_in.h = base_x;
                su_in.k = rd_base_x;
            end
            default:
            begin
                su_in = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        rc_next = rc_reg;
        bump_next = bump_reg;
        bank_next = bank_reg;
        i_next = i_reg;
        w_next = w_reg;
        placed_next = placed_reg;
        pend_next = pend_reg;
        ovf_next = ovf_reg;
        req_next = req_reg;
        status_next = status_reg;
        grant_next = grant_reg;
        pb_next = pb_reg;
        pe_next = pe_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next = rsp_reg;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re = 1'b0;
        mem_raddr = '0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    grant_next = '0;
                    i_next = '0;
                    status_next = ST_OK;
                    if (req.count == '0)
                    begin
                        status_next = ST_IGN;
                        state_next = S_MUL;
                    end
                    else if (req.opcode == OP_ALLOC)
                    begin
                        if (!heap_reg)
                        begin
                            status_next = ST_EXH;
                            state_next = S_MUL;
                        end
                        else
                        begin
                            state_next = (rc_reg == '0) ? S_A_BUMP : S_A_REQ;
                        end
                    end
                    else
                    begin
                        if (!heap_reg)
                        begin
                            status_next = ST_IGN;
                            state_next = S_MUL;
                        end
                        else
                        begin
                            state_next = S_R_CHK;
                        end
                    end
                end
            end

            S_A_REQ:
            begin
                mem_re = 1'b1;
                mem_raddr = {bank_reg, i_reg[IDX_W-1:0]};
                state_next = S_A_CHK;
            end

            S_A_CHK:
            begin
                if (su_out.ge)
                begin
                    grant_next = mem_rdata.base;
                    if (su_out.dif == '0)
                    begin
                        // emptied range: squeeze it out
                        if (more_after_i)
                        begin
                            state_next = S_A_SHREQ;
                        end
                        else
                        begin
                            rc_next = rc_reg - RC_W'(1);
                            state_next = S_MUL;
                        end
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        mem_waddr = {bank_reg, i_reg[IDX_W-1:0]};
                        mem_wdata.base = su_out.sum[CNT_W-1:0];
                        mem_wdata.len = su_out.dif[CNT_W-1:0];
                        state_next = S_MUL;
                    end
                end
                else if (more_after_i)
                begin
                    i_next = i_plus1[RC_W-1:0];
                    state_next = S_A_REQ;
                end
                else
                begin
                    state_next = S_A_BUMP;
                end
            end

            S_A_SHREQ:
            begin
                mem_re = 1'b1;
                mem_raddr = {bank_reg, i_plus1[IDX_W-1:0]};
                state_next = S_A_SHWR;
            end

            S_A_SHWR:
            begin
                mem_we = 1'b1;
                mem_waddr = {bank_reg, i_reg[IDX_W-1:0]};
                mem_wdata = mem_rdata;
                i_next = i_plus1[RC_W-1:0];
                if (more_after_i2)
                begin
                    state_next = S_A_SHREQ;
                end
                else
                begin
                    rc_next = rc_reg - RC_W'(1);
                    state_next = S_MUL;
                end
            end

            S_A_BUMP:
            begin
                if (su_out.le)
                begin
                    grant_next = bump_reg;
                    bump_next = su_out.sum[CNT_W-1:0];
                end
                else
                begin
                    status_next = ST_EXH;
                end
                state_next = S_MUL;
            end

            S_R_CHK:
            begin
                w_next = '0;
                placed_next = 1'b0;
                pend_next = 1'b0;
                ovf_next = 1'b0;
                if (su_out.ge || !su_out.le)
                begin
                    status_next = ST_IGN;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = (rc_reg == '0) ? S_R_LAST : S_R_REQ;
                end
            end

            S_R_REQ:
            begin
                mem_re = 1'b1;
                mem_raddr = {bank_reg, i_reg[IDX_W-1:0]};
                state_next = S_R_MRG;
            end

            S_R_MRG, S_R_LAST:
            begin
                if (state_reg == S_R_LAST && placed_reg)
                begin
                    state_next = S_R_FLUSH;
                end
                else
                begin
                    if (pend_reg && su_out.ge)
                    begin
                        // touching or overlapping: stretch the pending range
                        pe_next = su_out.le ? pe_reg : su_out.sum;
                    end
                    else
                    begin
                        if (pend_reg)
                        begin
                            if (w_reg == RC_W'(MAX_FREE_RANGES))
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                mem_waddr = {!bank_reg, w_reg[IDX_W-1:0]};
                                mem_wdata.base = pb_reg[CNT_W-1:0];
                                mem_wdata.len = su_out.len[CNT_W-1:0];
                                w_next = w_reg + RC_W'(1);
                            end
                        end
                        pend_next = 1'b1;
                        pb_next = rb_x;
                        pe_next = su_out.sum;
                    end

                    if (take_new)
                    begin
                        placed_next = 1'b1;
                        if (state_reg == S_R_LAST)
                        begin
                            state_next = S_R_FLUSH;
                        end
                    end
                    else if (more_after_i)
                    begin
                        i_next = i_plus1[RC_W-1:0];
                        state_next = S_R_REQ;
                    end
                    else
                    begin
                        state_next = S_R_LAST;
                    end
                end
            end

            S_R_FLUSH:
            begin
                if (ovf_reg || w_reg == RC_W'(MAX_FREE_RANGES))
                begin
                    // too many ranges: keep the old bank
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_waddr = {!bank_reg, w_reg[IDX_W-1:0]};
                    mem_wdata.base = pb_reg[CNT_W-1:0];
                    mem_wdata.len = su_out.len[CNT_W-1:0];
                    rc_next = w_reg + RC_W'(1);
                    bank_next = !bank_reg;
                end
                state_next = S_MUL;
            end

            S_MUL:
            begin
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // wait for the output register to free up
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.status = status_reg;
                    if (status_reg == ST_OK && req_reg.opcode == OP_ALLOC)
                    begin
                        rsp_next.alloc_base = grant_reg[BASE_W-1:0];
                        rsp_next.cpu_handle = cpu_start_reg + off_reg;
                        rsp_next.gpu_handle = shader_reg ? gpu_start_reg + off_reg : 64'd0;
                    end
                    else
                    begin
                        rsp_next.alloc_base = '0;
                        rsp_next.cpu_handle = '0;
                        rsp_next.gpu_handle = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rc_reg <= '0;
            bump_reg <= '0;
            bank_reg <= 1'b0;
            i_reg <= '0;
            w_reg <= '0;
            placed_reg <= 1'b0;
            pend_reg <= 1'b0;
            ovf_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            capacity_reg <= '0;
            dsize_reg <= '0;
            shader_reg <= 1'b0;
            heap_reg <= 1'b0;
            cpu_start_reg <= '0;
            gpu_start_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rc_reg <= rc_next;
            bump_reg <= bump_next;
            bank_reg <= bank_next;
            i_reg <= i_next;
            w_reg <= w_next;
            placed_reg <= placed_next;
            pend_reg <= pend_next;
            ovf_reg <= ovf_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CAPACITY:  capacity_reg <= cfg_data[CNT_W-1:0];
                    CFG_DESC_SIZE: dsize_reg <= cfg_data[11:0];
                    CFG_SHADER:    shader_reg <= cfg_data[0];
                    CFG_HEAP:      heap_reg <= cfg_data[0];
                    CFG_CPU_START: cpu_start_reg <= cfg_data;
                    CFG_GPU_START: gpu_start_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        status_reg <= status_next;
        grant_reg <= grant_next;
        pb_reg <= pb_next;
        pe_reg <= pe_next;
        rsp_reg <= rsp_next;
        // slot offset of the grant
        off_reg <= 64'({12'd0, grant_reg} * {{CNT_W{1'b0}}, dsize_reg});
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

    a_rc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rc_reg <= RC_W'(MAX_FREE_RANGES))
        else $error("free-range count above table size");

    a_bump_mono: assert property (@(posedge clk) disable iff (!rst_n)
        bump_reg >= $past(bump_reg))
        else $error("bump pointer moved backward");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status != ST_OK |->
            rsp_reg.alloc_base == '0 && rsp_reg.cpu_handle == '0 && rsp_reg.gpu_handle == '0)
        else $error("failed request carries a grant");

    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        bank_reg != $past(bank_reg) |-> $past(state_reg) == S_R_FLUSH)
        else $error("bank switched outside release commit");

endmodule

FILE: test/tb_range_allocator_first_fit_coalesce.sv
// testbench for the first-fit range allocator with coalescing free list
// runs directed and random allocate/release beats against a local table model
// depends on ralloc_pkg and range_allocator_first_fit_coalesce
module tb_range_allocator_first_fit_coalesce;
    import ralloc_pkg::*;

    localparam int NRANGES = 64;
    localparam int IDX_BITS = 20;
    localparam int RANDOM_BEATS = 1730;
    localparam int STALL_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    req_t                  req;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    range_allocator_first_fit_coalesce u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the allocator state
    logic [20:0] m_base [NRANGES];
    logic [20:0] m_len  [NRANGES];
    int          m_nranges;
    logic [20:0] m_bump;
    logic [20:0] r_capacity;
    logic [11:0] r_desc;
    logic        r_shader;
    logic        r_heap;
    logic [63:0] r_cpu;
    logic [63:0] r_gpu;

    rsp_t expected_rsps [$];
    int   fail_count;
    int   idle_cycles;
    int   send_gap_pct;
    int   recv_gap_pct;
    int   n_alloc_ok;
    int   n_release_ok;
    int   n_full;

    // directed beats: check flag set where the response is obvious
    typedef struct {
        req_t beat;
        bit   fixed;
        rsp_t want;
    } vec_t;

    always #1 clk = ~clk;

    function automatic logic [63:0] eff_cap();
        return (r_capacity > (21'd1 << IDX_BITS)) ? (64'd1 << IDX_BITS) : 64'(r_capacity);
    endfunction

    function automatic logic [1:0] release_run(logic [19:0] b, logic [20:0] n);
        logic [20:0] tb [NRANGES+1];
        logic [20:0] tl [NRANGES+1];
        logic [63:0] rb;
        logic [63:0] re;
        logic [63:0] pe;
        int k;
        int w;
        bit placed;
        k = 0;
        w = 0;
        placed = 0;
        if (n == 0 || !r_heap)
            return ST_IGN;
        if (64'(b) >= eff_cap() || 64'(b) + 64'(n) > eff_cap())
            return ST_IGN;
        for (int i = 0; i < m_nranges; i++)
        begin
            if (!placed && 21'(b) < m_base[i])
            begin
                tb[k] = 21'(b); tl[k] = n; k++;
                placed = 1;
            end
            tb[k] = m_base[i]; tl[k] = m_len[i]; k++;
        end
        if (!placed)
        begin
            tb[k] = 21'(b); tl[k] = n; k++;
        end
        // coalesce touching or overlapping neighbors
        for (int i = 0; i < k; i++)
        begin
            rb = 64'(tb[i]);
            re = rb + 64'(tl[i]);
            if (tl[i] == 0)
                continue;
            if (w > 0)
            begin
                pe = 64'(tb[w-1]) + 64'(tl[w-1]);
                if (rb <= pe)
                begin
                    tl[w-1] = 21'(((pe > re) ? pe : re) - 64'(tb[w-1]));
                    continue;
                end
            end
            tb[w] = tb[i]; tl[w] = tl[i]; w++;
        end
        if (w > NRANGES)
            return ST_FULL;
        for (int i = 0; i < w; i++)
        begin
            m_base[i] = tb[i];
            m_len[i] = tl[i];
        end
        m_nranges = w;
        return ST_OK;
    endfunction

    function automatic rsp_t predict_grant(req_t r);
        rsp_t o;
        logic [20:0] g;
        logic [63:0] off;
        bit got;
        o = '0;
        got = 0;
        g = '0;
        if (r.opcode == OP_RELEASE)
        begin
            o.status = release_run(r.base_index, r.count);
            if (o.status == ST_OK) n_release_ok++;
            if (o.status == ST_FULL) n_full++;
            return o;
        end
        if (r.count == 0)
        begin
            o.status = ST_IGN;
            return o;
        end
        if (!r_heap)
        begin
            o.status = ST_EXH;
            return o;
        end
        for (int i = 0; i < m_nranges && !got; i++)
        begin
            if (m_len[i] >= r.count)
            begin
                g = m_base[i];
                m_base[i] = m_base[i] + r.count;
                m_len[i] = m_len[i] - r.count;
                if (m_len[i] == 0)
                begin
                    for (int j = i; j + 1 < m_nranges; j++)
                    begin
                        m_base[j] = m_base[j+1];
                        m_len[j] = m_len[j+1];
                    end
                    m_nranges--;
                end
                got = 1;
            end
        end
        if (!got)
        begin
            if (64'(m_bump) + 64'(r.count) > eff_cap())
            begin
                o.status = ST_EXH;
                return o;
            end
            g = m_bump;
            m_bump = m_bump + r.count;
        end
        off = 64'(g) * 64'(r_desc);
        o.status = ST_OK;
        o.alloc_base = g[19:0];
        o.cpu_handle = r_cpu + off;
        o.gpu_handle = r_shader ? r_gpu + off : 64'd0;
        n_alloc_ok++;
        return o;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CAPACITY:  r_capacity = val[20:0];
            CFG_DESC_SIZE: r_desc = val[11:0];
            CFG_SHADER:    r_shader = val[0];
            CFG_HEAP:      r_heap = val[0];
            CFG_CPU_START: r_cpu = val;
            CFG_GPU_START: r_gpu = val;
            default: ;
        endcase
    endtask

    task automatic setup_heap(logic [20:0] cap, logic [11:0] ds, logic sv, logic hp,
                              logic [63:0] cs, logic [63:0] gs);
        write_reg(CFG_CAPACITY, 64'(cap));
        write_reg(CFG_DESC_SIZE, 64'(ds));
        write_reg(CFG_SHADER, 64'(sv));
        write_reg(CFG_HEAP, 64'(hp));
        write_reg(CFG_CPU_START, cs);
        write_reg(CFG_GPU_START, gs);
    endtask

    // block until the response queue is empty, plus latency slack
    task automatic drain_responses();
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    // send one beat; valid held until accepted, random gap before it
    task automatic send_beat(req_t r);
        rsp_t p;
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_gap_pct)
                @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        p = predict_grant(r);
        expected_rsps.insert(expected_rsps.size(), p);
    endtask

    function automatic req_t mk(logic op, logic [20:0] n, logic [19:0] b);
        req_t r;
        r.opcode = op;
        r.count = n;
        r.base_index = b;
        return r;
    endfunction

    // random beat mostly shaped to hit the table, occasionally noise
    function automatic req_t random_beat(int cap);
        req_t r;
        int sel;
        sel = $urandom_range(99);
        r.opcode = 1'($urandom_range(1));
        if (sel < 4)
        begin
            r.count = 21'($urandom);
            r.base_index = 20'($urandom);
        end
        else if (sel < 8)
        begin
            r.count = '0;
            r.base_index = 20'($urandom);
        end
        else
        begin
            r.count = 21'($urandom_range(1, (cap > 16) ? cap / 8 : 2));
            r.base_index = 20'($urandom_range(0, (cap > 0) ? cap - 1 : 0));
            if ($urandom_range(3) == 0)
                r.count = 21'($urandom_range(1, 3));
        end
        return r;
    endfunction

    // response side: random stall, compare against oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected response beat status=%0d", rsp.status);
                fail_count++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.alloc_base !== want.alloc_base)
                begin
                    $error("alloc_base expected %0h actual %0h", want.alloc_base,
                           rsp.alloc_base);
                    fail_count++;
                end
                if (rsp.cpu_handle !== want.cpu_handle)
                begin
                    $error("cpu_handle expected %0h actual %0h", want.cpu_handle,
                           rsp.cpu_handle);
                    fail_count++;
                end
                if (rsp.gpu_handle !== want.gpu_handle)
                begin
                    $error("gpu_handle expected %0h actual %0h", want.gpu_handle,
                           rsp.gpu_handle);
                    fail_count++;
                end
            end
        end
        if (rst_n)
            rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // watchdog: cycles with no beat on either channel and no config write
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        vec_t dir [$];
        vec_t v;
        rsp_t z;
        clk = 0;
        rst_n = 0;
        req_valid = 0;
        req = '0;
        rsp_ready = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        idle_cycles = 0;
        send_gap_pct = 0;
        recv_gap_pct = 0;
        n_alloc_ok = 0;
        n_release_ok = 0;
        n_full = 0;
        m_nranges = 0;
        m_bump = '0;
        r_capacity = '0;
        r_desc = '0;
        r_shader = 0;
        r_heap = 0;
        r_cpu = '0;
        r_gpu = '0;
        z = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // no heap after reset: allocate fails, release ignored
        v.fixed = 1; v.want = z;
        v.beat = mk(OP_ALLOC, 21'd4, '0); v.want.status = ST_EXH; dir.insert(dir.size(), v);
        v.beat = mk(OP_RELEASE, 21'd4, '0); v.want.status = ST_IGN; dir.insert(dir.size(), v);
        v.beat = mk(OP_ALLOC, 21'd0, '0); v.want.status = ST_IGN; dir.insert(dir.size(), v);
        foreach (dir[i])
        begin
            send_beat(dir[i].beat);
            if (dir[i].fixed)
                expected_rsps[$] = dir[i].want;
        end
        drain_responses();
        dir.delete();

        // full-size heap, extreme handles that wrap
        setup_heap(21'h1FFFFF, 12'hFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 64'hFFFF_FFFF_0000_0000);
        v.fixed = 0; v.want = z;
        v.beat = mk(OP_ALLOC, 21'd1, '0); dir.insert(dir.size(), v);
        v.beat = mk(OP_ALLOC, 21'h100000, '0); dir.insert(dir.size(), v);      // bump past capacity
        v.beat = mk(OP_ALLOC, 21'h0FFFFE, '0); dir.insert(dir.size(), v);      // fills all but the last slot
        v.beat = mk(OP_ALLOC, 21'd1, '0); dir.insert(dir.size(), v);
        v.beat = mk(OP_RELEASE, 21'd0, 20'd5); dir.insert(dir.size(), v);      // zero-length release
        v.beat = mk(OP_RELEASE, 21'd2, 20'hFFFFF); dir.insert(dir.size(), v);  // runs off the end
        v.beat = mk(OP_RELEASE, 21'd1, 20'hFFFFF); dir.insert(dir.size(), v);  // last slot
        v.beat = mk(OP_RELEASE, 21'd10, 20'd100); dir.insert(dir.size(), v);
        v.beat = mk(OP_RELEASE, 21'd10, 20'd110); dir.insert(dir.size(), v);   // touching neighbor
        v.beat = mk(OP_RELEASE, 21'd30, 20'd95); dir.insert(dir.size(), v);    // overlapping
        v.beat = mk(OP_RELEASE, 21'd5, 20'd50); dir.insert(dir.size(), v);
        v.beat = mk(OP_ALLOC, 21'd5, '0); dir.insert(dir.size(), v);           // empties first range
        v.beat = mk(OP_ALLOC, 21'd200, '0); dir.insert(dir.size(), v);         // no fit anywhere
        v.beat = mk(OP_ALLOC, 21'd7, '0); dir.insert(dir.size(), v);           // cut from front
        v.beat = mk(OP_RELEASE, 21'h100000, 20'd0); dir.insert(dir.size(), v); // whole heap
        v.beat = mk(OP_ALLOC, 21'h100000, '0); dir.insert(dir.size(), v);
        foreach (dir[i])
            send_beat(dir[i].beat);
        drain_responses();

        // fill the free table past its depth with separated single slots
        setup_heap(21'd400, 12'd0, 1'b0, 1'b1, 64'd0, 64'd0);
        for (int i = 0; i < 66; i++)
            send_beat(mk(OP_RELEASE, 21'd1, 20'(i * 3)));
        drain_responses();

        // random phases under different settings and idle patterns
        for (int ph = 0; ph < 3; ph++)
        begin
            int cap;
            send_gap_pct = (ph == 0) ? 9 : (ph == 1) ? 81 : 0;
            recv_gap_pct = (ph == 0) ? 81 : (ph == 1) ? 9 : 0;
            cap = (ph == 0) ? 512 : (ph == 1) ? 1048576 : 300;
            setup_heap(21'(cap), 12'($urandom), ph != 1, 1'b1, {$urandom, $urandom},
                       {$urandom, $urandom});
            for (int i = 0; i < RANDOM_BEATS / 3; i++)
            begin
                // hold off until everything is back once per phase
                if (i == 100)
                begin
                    req_valid <= 1'b0;
                    @(posedge clk);
                    while (expected_rsps.size() != 0)
                        @(posedge clk);
                end
                send_beat(random_beat(cap));
            end
            drain_responses();
        end
        // heap removed and capacity shrunk while ranges are held
        setup_heap(21'd0, 12'd1, 1'b0, 1'b0, 64'd0, 64'd0);
        for (int i = 0; i < 8; i++)
            send_beat(random_beat(16));
        drain_responses();

        $display("covered %0d granted allocates, %0d merged releases, %0d table-full refusals",
                 n_alloc_ok, n_release_ok, n_full);
        $display("across reset, full-width, small and no-heap settings with three idle mixes");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
